@@ src/fjv_pkg.sv @@
`timescale 1ns / 1ps

package fjv_pkg;

    typedef enum logic [4:0] {
        PH_OPEN, PH_FIRST, PH_KEYQ, PH_KEY, PH_KEYESC, PH_COLON, PH_VALUE,
        PH_VSTR, PH_VESC, PH_NSIGN, PH_NINT, PH_NZERO, PH_FRAC0, PH_FRAC,
        PH_EXP0, PH_EXPS, PH_EXP, PH_LIT, PH_NEXT, PH_DONE
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK, ST_NO_BRACE, ST_NO_KEY_QUOTE, ST_NO_COLON, ST_BAD_LITERAL,
        ST_TRUNC_STRING, ST_NO_DIGIT, ST_NO_FRAC_DIGIT, ST_NO_EXP_DIGIT,
        ST_ARRAY, ST_NESTED, ST_NO_COMMA, ST_TRAILING, ST_TOO_LONG
    } t_status;

    typedef struct packed {
        t_phase     phase;
        logic [2:0] lit_pos;
        logic [1:0] lit_kind;
    } t_parse_state;

    typedef struct packed {
        t_parse_state ps;
        logic         pair_inc;
        t_status      err;
    } t_step;

    localparam t_parse_state PS_RESET = '{phase: PH_OPEN, lit_pos: 3'd0, lit_kind: 2'd0};

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_DIG0   = "0";
    localparam logic [7:0] CH_DIG9   = "9";
    localparam logic [7:0] CH_EXP_LO = "e";
    localparam logic [7:0] CH_EXP_UP = "E";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = "n";
    localparam logic [7:0] CH_T      = "t";
    localparam logic [7:0] CH_F      = "f";

    localparam logic [1:0] LIT_NULL  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;

    // letters after the first one of null, true, false
    localparam logic [7:0] LIT_CHARS [3][4] = '{
        '{"u", "l", "l", 8'h00},
        '{"r", "u", "e", 8'h00},
        '{"a", "l", "s", "e"}
    };
    localparam logic [2:0] LIT_LEN [3] = '{3'd3, 3'd3, 3'd4};

endpackage

@@ src/fjv_byte_if.sv @@
`timescale 1ns / 1ps

interface fjv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

@@ src/fjv_result_if.sv @@
`timescale 1ns / 1ps

interface fjv_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [15:0] error_offset;
    logic [15:0] member_count;

    modport source (output valid, output status, output error_offset,
                    output member_count, input ready);
    modport sink (input valid, input status, input error_offset,
                  input member_count, output ready);
endinterface

@@ src/fjv_cfg_if.sv @@
`timescale 1ns / 1ps

interface fjv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_event_length;

    modport source (output valid, output max_event_length, input ready);
    modport sink (input valid, input max_event_length, output ready);
endinterface

@@ src/fjv_advance.sv @@
`timescale 1ns / 1ps

module fjv_advance (
    input  fjv_pkg::t_parse_state i_ps,
    input  logic [7:0]            i_byte,
    output fjv_pkg::t_step        o_step
);
    import fjv_pkg::*;

    logic       is_dig;
    logic       is_exp;
    logic [1:0] lit_k;
    logic [2:0] lit_nx;
    t_step      num_end;

    assign is_dig = (i_byte >= CH_DIG0) && (i_byte <= CH_DIG9);
    assign is_exp = (i_byte == CH_EXP_LO) || (i_byte == CH_EXP_UP);
    assign lit_k  = (i_ps.lit_kind == 2'd3) ? LIT_NULL : i_ps.lit_kind;
    assign lit_nx = i_ps.lit_pos + 3'd1;

    // number ends here, the same byte is checked as a separator
    always_comb begin
        num_end          = '{ps: i_ps, pair_inc: 1'b1, err: ST_OK};
        num_end.ps.phase = PH_NEXT;
        if (i_byte == CH_COMMA) begin
            num_end.ps.phase = PH_KEYQ;
        end else if (i_byte == CH_RBRACE) begin
            num_end.ps.phase = PH_DONE;
        end else begin
            num_end.err = ST_NO_COMMA;
        end
    end

    always_comb begin
        o_step = '{ps: i_ps, pair_inc: 1'b0, err: ST_OK};
        unique case (i_ps.phase)
            PH_OPEN: begin
                if (i_byte == CH_LBRACE) o_step.ps.phase = PH_FIRST;
                else o_step.err = ST_NO_BRACE;
            end
            PH_FIRST: begin
                if (i_byte == CH_RBRACE) o_step.ps.phase = PH_DONE;
                else if (i_byte == CH_QUOTE) o_step.ps.phase = PH_KEY;
                else o_step.err = ST_NO_KEY_QUOTE;
            end
            PH_KEYQ: begin
                if (i_byte == CH_QUOTE) o_step.ps.phase = PH_KEY;
                else o_step.err = ST_NO_KEY_QUOTE;
            end
            PH_KEY: begin
                if (i_byte == CH_NUL) o_step.err = ST_TRUNC_STRING;
                else if (i_byte == CH_BSLASH) o_step.ps.phase = PH_KEYESC;
                else if (i_byte == CH_QUOTE) o_step.ps.phase = PH_COLON;
            end
            PH_VSTR: begin
                if (i_byte == CH_NUL) begin
                    o_step.err = ST_TRUNC_STRING;
                end else if (i_byte == CH_BSLASH) begin
                    o_step.ps.phase = PH_VESC;
                end else if (i_byte == CH_QUOTE) begin
                    o_step.ps.phase = PH_NEXT;
                    o_step.pair_inc = 1'b1;
                end
            end
            PH_KEYESC: begin
                if (i_byte == CH_NUL) o_step.err = ST_TRUNC_STRING;
                else o_step.ps.phase = PH_KEY;
            end
            PH_VESC: begin
                if (i_byte == CH_NUL) o_step.err = ST_TRUNC_STRING;
                else o_step.ps.phase = PH_VSTR;
            end
            PH_COLON: begin
                if (i_byte == CH_COLON) o_step.ps.phase = PH_VALUE;
                else o_step.err = ST_NO_COLON;
            end
            PH_VALUE: begin
                if (i_byte == CH_QUOTE) begin
                    o_step.ps.phase = PH_VSTR;
                end else if (i_byte == CH_MINUS) begin
                    o_step.ps.phase = PH_NSIGN;
                end else if (i_byte == CH_N || i_byte == CH_T || i_byte == CH_F) begin
                    o_step.ps.phase    = PH_LIT;
                    o_step.ps.lit_pos  = 3'd0;
                    o_step.ps.lit_kind = (i_byte == CH_N) ? LIT_NULL :
                                         (i_byte == CH_T) ? LIT_TRUE : LIT_FALSE;
                end else if (i_byte == CH_LBRACK) begin
                    o_step.err = ST_ARRAY;
                end else if (i_byte == CH_LBRACE) begin
                    o_step.err = ST_NESTED;
                end else if (i_byte == CH_DIG0) begin
                    o_step.ps.phase = PH_NZERO;
                end else if (is_dig) begin
                    o_step.ps.phase = PH_NINT;
                end else begin
                    o_step.err = ST_NO_DIGIT;
                end
            end
            PH_NSIGN: begin
                if (i_byte == CH_DIG0) o_step.ps.phase = PH_NZERO;
                else if (is_dig) o_step.ps.phase = PH_NINT;
                else o_step.err = ST_NO_DIGIT;
            end
            PH_NINT: begin
                if (is_dig) o_step.ps.phase = PH_NINT;
                else if (i_byte == CH_DOT) o_step.ps.phase = PH_FRAC0;
                else if (is_exp) o_step.ps.phase = PH_EXP0;
                else o_step = num_end;
            end
            PH_NZERO: begin
                if (i_byte == CH_DOT) o_step.ps.phase = PH_FRAC0;
                else if (is_exp) o_step.ps.phase = PH_EXP0;
                else o_step = num_end;
            end
            PH_FRAC0: begin
                if (is_dig) o_step.ps.phase = PH_FRAC;
                else o_step.err = ST_NO_FRAC_DIGIT;
            end
            PH_FRAC: begin
                if (is_dig) o_step.ps.phase = PH_FRAC;
                else if (is_exp) o_step.ps.phase = PH_EXP0;
                else o_step = num_end;
            end
            PH_EXP0: begin
                if (i_byte == CH_MINUS || i_byte == CH_PLUS) o_step.ps.phase = PH_EXPS;
                else if (is_dig) o_step.ps.phase = PH_EXP;
                else o_step.err = ST_NO_EXP_DIGIT;
            end
            PH_EXPS: begin
                if (is_dig) o_step.ps.phase = PH_EXP;
                else o_step.err = ST_NO_EXP_DIGIT;
            end
            PH_EXP: begin
                if (is_dig) o_step.ps.phase = PH_EXP;
                else o_step = num_end;
            end
            PH_LIT: begin
                if (i_ps.lit_pos >= LIT_LEN[lit_k] ||
                    i_byte != LIT_CHARS[lit_k][i_ps.lit_pos[1:0]]) begin
                    o_step.err = ST_BAD_LITERAL;
                end else begin
                    o_step.ps.lit_pos = lit_nx;
                    if (lit_nx == LIT_LEN[lit_k]) begin
                        o_step.ps.phase = PH_NEXT;
                        o_step.pair_inc = 1'b1;
                    end
                end
            end
            PH_NEXT: begin
                if (i_byte == CH_COMMA) o_step.ps.phase = PH_KEYQ;
                else if (i_byte == CH_RBRACE) o_step.ps.phase = PH_DONE;
                else o_step.err = ST_NO_COMMA;
            end
            default: begin
                if (i_byte != CH_NUL) o_step.err = ST_TRAILING;
            end
        endcase
    end
endmodule

@@ src/flat_json_object_validator_core.sv @@
`timescale 1ns / 1ps

// Checks a byte stream in which a zero byte ends each event: every event must
// be one flat JSON object without whitespace. One byte is taken per clock
// unless a terminating zero byte is stalled. A byte is held in the input
// register, where the parse stage checks it against the event state; the
// terminating zero byte writes a status, stop offset and member count into the
// result register (an empty event gives no result). Bytes keep streaming while
// a result waits; only a zero byte that ends a non-empty event stalls until the
// waiting result has been taken. The limit register may be written only while
// no event is in progress.
module flat_json_object_validator_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fjv_cfg_if.sink       i_cfg,
    fjv_byte_if.sink      i_in,
    fjv_result_if.source  o_out
);
    import fjv_pkg::*;

    localparam int EW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [EW-1:0] OUT_MAX = EW'(17'h0ffff);

    function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        return (ext > OUT_MAX) ? 16'hffff : ext[15:0];
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] inc_sat(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    logic [15:0]            r_max_len;
    logic                   r_s1_valid, n_s1_valid;
    logic [7:0]             r_s1_byte;
    t_parse_state           r_ps, n_ps;
    t_status                r_err, n_err;
    logic [COUNT_WIDTH-1:0] r_stop, n_stop;
    logic [COUNT_WIDTH-1:0] r_pos, n_pos;
    logic [COUNT_WIDTH-1:0] r_pairs, n_pairs;
    logic                   r_out_valid, n_out_valid;
    t_status                r_out_status, n_out_status;
    logic [15:0]            r_out_offset, n_out_offset;
    logic [15:0]            r_out_count, n_out_count;

    t_step step;
    logic  s1_zero, s1_result, s1_go, too_long, out_free;

    fjv_advance u_advance (
        .i_ps   (r_ps),
        .i_byte (r_s1_byte),
        .o_step (step)
    );

    assign s1_zero   = (r_s1_byte == CH_NUL);
    assign s1_result = s1_zero && !(r_pos == '0 && r_err == ST_OK);
    assign out_free  = !r_out_valid || o_out.ready;
    assign s1_go     = r_s1_valid && (!s1_result || out_free);
    assign too_long  = EW'(r_pos) >= EW'(r_max_len);

    assign i_in.ready         = !r_s1_valid || s1_go;
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = 4'(r_out_status);
    assign o_out.error_offset = r_out_offset;
    assign o_out.member_count = r_out_count;

    always_comb begin
        n_s1_valid   = (r_s1_valid && !s1_go) || (i_in.valid && i_in.ready);
        n_ps         = r_ps;
        n_err        = r_err;
        n_stop       = r_stop;
        n_pos        = r_pos;
        n_pairs      = r_pairs;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_offset = r_out_offset;
        n_out_count  = r_out_count;
        if (s1_go) begin
            if (!s1_zero) begin
                if (too_long) begin
                    if (r_err != ST_TOO_LONG) begin
                        n_err  = ST_TOO_LONG;
                        n_stop = r_pos;
                    end
                end else if (r_err == ST_OK) begin
                    n_ps = step.ps;
                    if (step.pair_inc) n_pairs = inc_sat(r_pairs);
                    if (step.err != ST_OK) begin
                        n_err  = step.err;
                        n_stop = r_pos;
                    end
                end
                n_pos = inc_sat(r_pos);
            end else begin
                if (s1_result) begin
                    n_out_valid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_out_status = r_err;
                        n_out_offset = sat16(r_stop);
                        n_out_count  = sat16(r_pairs);
                    end else begin
                        n_out_status = step.err;
                        n_out_offset = sat16(r_pos);
                        n_out_count  = sat16(step.pair_inc ? inc_sat(r_pairs) : r_pairs);
                    end
                end
                n_ps    = PS_RESET;
                n_err   = ST_OK;
                n_stop  = '0;
                n_pos   = '0;
                n_pairs = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= 16'hffff;
            r_s1_valid  <= 1'b0;
            r_ps        <= PS_RESET;
            r_err       <= ST_OK;
            r_stop      <= '0;
            r_pos       <= '0;
            r_pairs     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_max_len <= i_cfg.max_event_length;
            r_s1_valid  <= n_s1_valid;
            r_ps        <= n_ps;
            r_err       <= n_err;
            r_stop      <= n_stop;
            r_pos       <= n_pos;
            r_pairs     <= n_pairs;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) r_s1_byte <= i_in.data_byte;
        r_out_status <= n_out_status;
        r_out_offset <= n_out_offset;
        r_out_count  <= n_out_count;
    end

`ifndef SYNTHESIS
    a_result_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && !s1_zero) |=> !$rose(r_out_valid))
        else $error("result raised by a nonzero byte");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_zero) |=> (r_pos == '0 && r_err == ST_OK && r_pairs == '0))
        else $error("event state not cleared after terminating byte");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && !(s1_go && s1_zero))
        |=> (r_err == $past(r_err) || r_err == ST_TOO_LONG))
        else $error("error code changed inside an event");

    a_pairs_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pairs <= r_pos)
        else $error("member count exceeds byte count");
`endif
endmodule
